@@ rtl/core/pm1_pkg.sv @@
// ----------------------------------------------------------------------------
// pm1_pkg: shared types and constants for the P-1 stage 1 block
// Sequencer states, ALU opcodes, configuration and result bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package pm1_pkg;

    localparam int DATA_W = 64;

    // input selector codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_WORDS   = 2'd0;
    localparam logic [1:0] REG_LEAD    = 2'd1;
    localparam logic [1:0] REG_EXTRA   = 2'd2;
    localparam logic [1:0] REG_S1_ONLY = 2'd3;

    typedef enum logic [1:0] {
        ALU_ADDMOD,
        ALU_SUB,
        ALU_ADD
    } alu_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_WNEXT,
        S_WREAD,
        S_BIT,
        S_MDBL,
        S_MADD,
        S_BITDBL,
        S_XSQ,
        S_XCHK,
        S_G0,
        S_G1,
        S_GCD,
        S_INV0,
        S_IV,
        S_IVV,
        S_IVX,
        S_IVF,
        S_SUM,
        S_RM,
        S_FIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [5:0] words;
        logic [5:0] lead;
        logic [5:0] extra;
        logic       s1_only;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] factor;
        logic [DATA_W-1:0] x_sum;
        logic              continued;
        logic              backtracked;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/core/pm1_alu.sv @@
// ----------------------------------------------------------------------------
// pm1_alu: shared modular adder / subtractor
// One 65-bit add with reduction against the modulus, or a plain add/subtract
// with carry or borrow out.
// ----------------------------------------------------------------------------
`default_nettype none

module pm1_alu (
    input  wire pm1_pkg::alu_op_t             op,
    input  wire logic [pm1_pkg::DATA_W-1:0]   a,
    input  wire logic [pm1_pkg::DATA_W-1:0]   b,
    input  wire logic [pm1_pkg::DATA_W-1:0]   n,
    output logic      [pm1_pkg::DATA_W-1:0]   res,
    output logic                              flag
);
    import pm1_pkg::*;

    logic [DATA_W:0] sum;
    logic [DATA_W:0] red;
    logic [DATA_W:0] dif;

    assign sum = {1'b0, a} + {1'b0, b};
    assign red = sum - {1'b0, n};
    assign dif = {1'b0, a} - {1'b0, b};

    always_comb
    begin
        res  = sum[DATA_W-1:0];
        flag = 1'b0;
        unique case (op)
            ALU_ADDMOD:
            begin
                res  = (sum >= {1'b0, n}) ? red[DATA_W-1:0] : sum[DATA_W-1:0];
                flag = 1'b0;
            end
            ALU_SUB:
            begin
                res  = dif[DATA_W-1:0];
                flag = dif[DATA_W];
            end
            ALU_ADD:
            begin
                res  = sum[DATA_W-1:0];
                flag = sum[DATA_W];
            end
            default:
            begin
                res  = sum[DATA_W-1:0];
                flag = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/pm1_seq.sv @@
// ----------------------------------------------------------------------------
// pm1_seq: exponent store and sequencer for P-1 stage 1
// Drives the shared ALU through modular squaring, binary gcd, binary
// inverse and the final Montgomery conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module pm1_seq #(
    parameter int EXP_WORDS = 32,
    parameter int MOD_BITS  = 64
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire pm1_pkg::cfg_t               cfg,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        in_func,
    input  wire logic [4:0]                  in_index,
    input  wire logic [pm1_pkg::DATA_W-1:0]  in_word,
    input  wire logic [pm1_pkg::DATA_W-1:0]  in_modulus,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output pm1_pkg::res_t                    res
);
    import pm1_pkg::*;

    localparam int IDX_W = (EXP_WORDS > 1) ? $clog2(EXP_WORDS) : 1;
    localparam int WCAP  = (EXP_WORDS < 63) ? EXP_WORDS : 63;
    localparam logic [DATA_W-1:0] MOD_MASK = {DATA_W{1'b1}} >> (DATA_W - MOD_BITS);
    localparam logic [6:0] CNT_TOP = 7'(MOD_BITS - 1);

    logic [DATA_W-1:0] mem [EXP_WORDS];
    logic [DATA_W-1:0] rdata_reg;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic [DATA_W-1:0] n_reg, n_next;
    logic [DATA_W-1:0] one_reg, one_next;
    logic [DATA_W-1:0] t_reg, t_next;
    logic [DATA_W-1:0] r_reg, r_next;
    logic [DATA_W-1:0] ma_reg, ma_next;
    logic [DATA_W-1:0] mb_reg, mb_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic [DATA_W-1:0] x1_reg, x1_next;
    logic [DATA_W-1:0] x2_reg, x2_next;
    logic [DATA_W-1:0] factor_reg, factor_next;
    logic [DATA_W-1:0] xsum_reg, xsum_next;
    logic [5:0] k_reg, k_next;
    logic [5:0] pos_reg, pos_next;
    logic [5:0] i_reg, i_next;
    logic [6:0] cnt_reg, cnt_next;
    logic hasb_reg, hasb_next;
    logic bt_reg, bt_next;
    logic sel_reg, sel_next;
    logic cont_reg, cont_next;

    alu_op_t alu_op;
    logic [DATA_W-1:0] alu_a, alu_b, alu_res;
    logic alu_flag;

    logic [15:0] waddr, raddr;
    logic [DATA_W-1:0] one_init;
    logic [DATA_W-1:0] xs, xo;
    logic load_we;

    pm1_alu u_alu (
        .op   (alu_op),
        .a    (alu_a),
        .b    (alu_b),
        .n    (n_reg),
        .res  (alu_res),
        .flag (alu_flag)
    );

    assign waddr   = 16'(in_index);
    assign raddr   = 16'(k_reg - 6'd1);
    assign load_we = in_valid && in_ready && (in_func == FUNC_LOAD)
                     && (32'(in_index) < EXP_WORDS);

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            mem[waddr[IDX_W-1:0]] <= in_word;
        end
        rdata_reg <= mem[raddr[IDX_W-1:0]];
    end

    assign one_init = (n_reg == {{(DATA_W-1){1'b0}}, 1'b1}) ? '0 : {{(DATA_W-1){1'b0}}, 1'b1};
    assign xs = sel_reg ? x2_reg : x1_reg;
    assign xo = sel_reg ? x1_reg : x2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        one_reg    <= one_next;
        t_reg      <= t_next;
        r_reg      <= r_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        x1_reg     <= x1_next;
        x2_reg     <= x2_next;
        factor_reg <= factor_next;
        xsum_reg   <= xsum_next;
        k_reg      <= k_next;
        pos_reg    <= pos_next;
        i_reg      <= i_next;
        cnt_reg    <= cnt_next;
        hasb_reg   <= hasb_next;
        bt_reg     <= bt_next;
        sel_reg    <= sel_next;
        cont_reg   <= cont_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        n_next      = n_reg;
        one_next    = one_reg;
        t_next      = t_reg;
        r_next      = r_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        x1_next     = x1_reg;
        x2_next     = x2_reg;
        factor_next = factor_reg;
        xsum_next   = xsum_reg;
        k_next      = k_reg;
        pos_next    = pos_reg;
        i_next      = i_reg;
        cnt_next    = cnt_reg;
        hasb_next   = hasb_reg;
        bt_next     = bt_reg;
        sel_next    = sel_reg;
        cont_next   = cont_reg;
        alu_op      = ALU_ADDMOD;
        alu_a       = r_reg;
        alu_b       = r_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (in_func == FUNC_RUN))
                begin
                    n_next     = in_modulus & MOD_MASK;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                if (!n_reg[0])
                begin
                    // even modulus: report it as the factor
                    factor_next = n_reg;
                    xsum_next   = '0;
                    cont_next   = 1'b0;
                    bt_next     = 1'b0;
                    state_next  = S_DONE;
                end
                else
                begin
                    alu_a      = one_init;
                    alu_b      = one_init;
                    one_next   = one_init;
                    t_next     = alu_res;
                    k_next     = (cfg.words > 6'(WCAP)) ? 6'(WCAP) : cfg.words;
                    pos_next   = cfg.lead - 6'd1;
                    hasb_next  = (cfg.lead != 6'd0);
                    bt_next    = 1'b0;
                    state_next = S_WNEXT;
                end
            end
            S_WNEXT:
            begin
                if (k_reg == 6'd0)
                begin
                    i_next     = 6'd0;
                    state_next = S_XSQ;
                end
                else
                begin
                    state_next = S_WREAD;
                end
            end
            S_WREAD:
            begin
                if (!hasb_reg)
                begin
                    k_next     = k_reg - 6'd1;
                    pos_next   = 6'd63;
                    hasb_next  = 1'b1;
                    state_next = S_WNEXT;
                end
                else
                begin
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                ma_next    = t_reg;
                mb_next    = t_reg;
                r_next     = '0;
                cnt_next   = CNT_TOP;
                ret_next   = S_BITDBL;
                state_next = S_MDBL;
            end
            S_MDBL:
            begin
                r_next = alu_res;
                if (mb_reg[cnt_reg[5:0]])
                begin
                    state_next = S_MADD;
                end
                else if (cnt_reg == 7'd0)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    cnt_next = cnt_reg - 7'd1;
                end
            end
            S_MADD:
            begin
                alu_b  = ma_reg;
                r_next = alu_res;
                if (cnt_reg == 7'd0)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    cnt_next   = cnt_reg - 7'd1;
                    state_next = S_MDBL;
                end
            end
            S_BITDBL:
            begin
                t_next = rdata_reg[pos_reg] ? alu_res : r_reg;
                if (pos_reg == 6'd0)
                begin
                    k_next     = k_reg - 6'd1;
                    pos_next   = 6'd63;
                    state_next = S_WNEXT;
                end
                else
                begin
                    pos_next   = pos_reg - 6'd1;
                    state_next = S_BIT;
                end
            end
            S_XSQ:
            begin
                if (i_reg == cfg.extra)
                begin
                    state_next = S_G0;
                end
                else
                begin
                    ma_next    = t_reg;
                    mb_next    = t_reg;
                    r_next     = '0;
                    cnt_next   = CNT_TOP;
                    ret_next   = S_XCHK;
                    state_next = S_MDBL;
                end
            end
            S_XCHK:
            begin
                // hit one: keep the value before it
                if (r_reg == one_reg)
                begin
                    bt_next    = 1'b1;
                    state_next = S_G0;
                end
                else
                begin
                    t_next     = r_reg;
                    i_next     = i_reg + 6'd1;
                    state_next = S_XSQ;
                end
            end
            S_G0:
            begin
                alu_op = ALU_SUB;
                alu_a  = t_reg;
                alu_b  = one_reg;
                a_next = alu_res;
                b_next = n_reg;
                state_next = alu_flag ? S_G1 : S_GCD;
            end
            S_G1:
            begin
                alu_op     = ALU_ADD;
                alu_a      = a_reg;
                alu_b      = n_reg;
                a_next     = alu_res;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                alu_op = ALU_SUB;
                alu_a  = a_reg;
                alu_b  = b_reg;
                if (a_reg == '0)
                begin
                    factor_next = b_reg;
                    if ((b_reg != {{(DATA_W-1){1'b0}}, 1'b1}) || cfg.s1_only)
                    begin
                        xsum_next  = '0;
                        cont_next  = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_INV0;
                    end
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!alu_flag)
                begin
                    a_next = alu_res;
                end
                else
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
            end
            S_INV0:
            begin
                if (n_reg == {{(DATA_W-1){1'b0}}, 1'b1})
                begin
                    x1_next    = '0;
                    state_next = S_SUM;
                end
                else
                begin
                    a_next     = t_reg;
                    b_next     = n_reg;
                    x1_next    = {{(DATA_W-1){1'b0}}, 1'b1};
                    x2_next    = '0;
                    state_next = S_IV;
                end
            end
            S_IV:
            begin
                alu_op = ALU_SUB;
                alu_a  = a_reg;
                alu_b  = b_reg;
                if (a_reg == {{(DATA_W-1){1'b0}}, 1'b1})
                begin
                    state_next = S_SUM;
                end
                else if (b_reg == {{(DATA_W-1){1'b0}}, 1'b1})
                begin
                    x1_next    = x2_reg;
                    state_next = S_SUM;
                end
                else if (!a_reg[0])
                begin
                    // halve u and its coefficient mod n
                    alu_op  = ALU_ADD;
                    alu_a   = x1_reg;
                    alu_b   = n_reg;
                    a_next  = a_reg >> 1;
                    x1_next = x1_reg[0] ? {alu_flag, alu_res[DATA_W-1:1]} : (x1_reg >> 1);
                end
                else if (!b_reg[0])
                begin
                    alu_op  = ALU_ADD;
                    alu_a   = x2_reg;
                    alu_b   = n_reg;
                    b_next  = b_reg >> 1;
                    x2_next = x2_reg[0] ? {alu_flag, alu_res[DATA_W-1:1]} : (x2_reg >> 1);
                end
                else if (!alu_flag)
                begin
                    a_next     = alu_res;
                    sel_next   = 1'b0;
                    state_next = S_IVX;
                end
                else
                begin
                    state_next = S_IVV;
                end
            end
            S_IVV:
            begin
                alu_op     = ALU_SUB;
                alu_a      = b_reg;
                alu_b      = a_reg;
                b_next     = alu_res;
                sel_next   = 1'b1;
                state_next = S_IVX;
            end
            S_IVX:
            begin
                alu_op = ALU_SUB;
                alu_a  = xs;
                alu_b  = xo;
                if (sel_reg)
                begin
                    x2_next = alu_res;
                end
                else
                begin
                    x1_next = alu_res;
                end
                state_next = alu_flag ? S_IVF : S_IV;
            end
            S_IVF:
            begin
                alu_op = ALU_ADD;
                alu_a  = xs;
                alu_b  = n_reg;
                if (sel_reg)
                begin
                    x2_next = alu_res;
                end
                else
                begin
                    x1_next = alu_res;
                end
                state_next = S_IV;
            end
            S_SUM:
            begin
                alu_a      = x1_reg;
                alu_b      = t_reg;
                a_next     = alu_res;
                b_next     = one_reg;
                cnt_next   = CNT_TOP;
                state_next = S_RM;
            end
            S_RM:
            begin
                // R mod n by repeated doubling
                alu_a  = b_reg;
                alu_b  = b_reg;
                b_next = alu_res;
                if (cnt_reg == 7'd0)
                begin
                    ma_next    = a_reg;
                    mb_next    = alu_res;
                    r_next     = '0;
                    cnt_next   = CNT_TOP;
                    ret_next   = S_FIN;
                    state_next = S_MDBL;
                end
                else
                begin
                    cnt_next = cnt_reg - 7'd1;
                end
            end
            S_FIN:
            begin
                xsum_next  = r_reg;
                cont_next  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.factor      = factor_reg;
    assign res.x_sum       = xsum_reg;
    assign res.continued   = cont_reg;
    assign res.backtracked = cont_reg & bt_reg;

endmodule

`default_nettype wire

@@ rtl/core/pm1_stage1_modexp.sv @@
// ----------------------------------------------------------------------------
// pm1_stage1_modexp: Pollard P-1 stage 1 engine
// Configuration registers, request/result handshake and output register
// around the sequencer and its shared modular ALU.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_*       in   tuser func, tdata {modulus, word_value, word_index}
//  m_*       out  tdata {backtracked, continued, x_sum, factor}
//  cfg_*     in   write-only register port, index 0..3
//
//  A run request squares once per exponent bit or further squaring, with
//  one doubling per multiplier bit plus one add per set bit after a setup
//  step, then runs a gcd and an inverse, all on the single shared adder.
//  Reset clears control and configuration; the exponent store is not
//  cleared. A finished result waits in the output register; the
//  sequencer holds while that register is full and not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pm1_stage1_modexp #(
    parameter int EXP_WORDS = 32,
    parameter int MOD_BITS  = 64
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire [135:0]  s_tdata,   // word_index[4:0], word_value[68:5], modulus[132:69]
    input  wire          s_tuser,   // func
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [135:0] m_tdata,   // factor[63:0], x_sum[127:64], continued[128],
                                    // backtracked[129]
    input  wire          cfg_we,
    input  wire [1:0]    cfg_addr,
    input  wire [5:0]    cfg_wdata
);
    import pm1_pkg::*;

    cfg_t cfg_reg;
    res_t seq_res;
    logic seq_valid, seq_ready;
    logic m_valid_reg;
    logic [135:0] m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.words   <= 6'd1;
            cfg_reg.lead    <= 6'd0;
            cfg_reg.extra   <= 6'd0;
            cfg_reg.s1_only <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_WORDS:   cfg_reg.words   <= cfg_wdata;
                REG_LEAD:    cfg_reg.lead    <= cfg_wdata;
                REG_EXTRA:   cfg_reg.extra   <= cfg_wdata;
                REG_S1_ONLY: cfg_reg.s1_only <= cfg_wdata[0];
                default:     cfg_reg.words   <= cfg_reg.words;
            endcase
        end
    end

    pm1_seq #(
        .EXP_WORDS (EXP_WORDS),
        .MOD_BITS  (MOD_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser),
        .in_index   (s_tdata[4:0]),
        .in_word    (s_tdata[68:5]),
        .in_modulus (s_tdata[132:69]),
        .res_valid  (seq_valid),
        .res_ready  (seq_ready),
        .res        (seq_res)
    );

    assign seq_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (seq_valid && seq_ready)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_valid && seq_ready)
        begin
            m_data_reg <= {6'd0, seq_res.backtracked, seq_res.continued,
                           seq_res.x_sum, seq_res.factor};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == FUNC_RUN)) |=> !s_tready)
        else $error("request taken while a run is in progress");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == FUNC_LOAD)) |=> !$rose(m_tvalid))
        else $error("load request produced a result");

    a_cont_factor: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[128]) |-> (m_tdata[63:0] == 64'd1))
        else $error("continued result with a nontrivial factor");
`endif

endmodule

`default_nettype wire

@@ tb/pm1_stage1_modexp_tb.sv @@
// ----------------------------------------------------------------------------
// pm1_stage1_modexp_tb: self-checking bench for the P-1 stage 1 engine
// Loads the exponent store, walks a short table of directed requests, then
// random phases of loads and runs under several register settings. Every
// result is checked field by field against a behavioral predictor or the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pm1_stage1_modexp_tb;

    import pm1_pkg::*;

    localparam int NWORDS = 32;

    typedef struct {
        logic        func;
        logic [4:0]  idx;
        logic [63:0] word;
        logic [63:0] modulus;
        bit          typed;
        logic [63:0] factor;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [5:0]   cfg_wdata;

    logic [63:0] exp_word [NWORDS];
    cfg_t        cur_cfg;
    res_t        pending_results [$];
    int          errors;
    int          results_seen;
    int          runs_sent;
    int          loads_sent;
    bit          no_idle;
    bit          held_off;
    row_t        dir_rows [$];

    pm1_stage1_modexp i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [63:0] mul_n(logic [63:0] a, logic [63:0] b, logic [63:0] n);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p % {64'd0, n});
    endfunction

    function automatic logic [63:0] add_n(logic [63:0] a, logic [63:0] b, logic [63:0] n);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return 64'(s % {1'b0, n});
    endfunction

    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // extended Euclid; coefficients stay within +-n
    function automatic logic [63:0] inverse_n(logic [63:0] a, logic [63:0] n);
        logic [63:0]         r0, r1, r2, q;
        logic signed [131:0] c0, c1, c2;
        r0 = n;
        r1 = a;
        c0 = 0;
        c1 = 1;
        while (r1 != 0)
        begin
            q  = r0 / r1;
            r2 = r0 - q * r1;
            c2 = c0 - $signed({68'd0, q}) * c1;
            r0 = r1;
            r1 = r2;
            c0 = c1;
            c1 = c2;
        end
        c0 = c0 % $signed({68'd0, n});
        if (c0 < 0)
            c0 = c0 + $signed({68'd0, n});
        return 64'(c0);
    endfunction

    function automatic res_t stage1_result(logic [63:0] n);
        res_t        r;
        logic [63:0] one, t, x, e, mask, f, sum;
        logic [127:0] wide;
        int          nw;
        bit          bt;
        r  = '0;
        bt = 0;
        if (n[0] == 1'b0)
        begin
            r.factor = n;
            return r;
        end
        one = (n == 1) ? 64'd0 : 64'd1;
        t   = add_n(one, one, n);
        nw  = (cur_cfg.words > NWORDS) ? NWORDS : int'(cur_cfg.words);
        mask = (64'd1 << cur_cfg.lead) >> 1;
        for (int k = nw; k > 0; k--)
        begin
            e = exp_word[k-1];
            while (mask != 0)
            begin
                t = mul_n(t, t, n);
                if ((e & mask) != 0)
                    t = add_n(t, t, n);
                mask = mask >> 1;
            end
            mask = 64'h8000_0000_0000_0000;
        end
        x = t;
        for (int i = 0; i < int'(cur_cfg.extra); i++)
        begin
            x = mul_n(x, x, n);
            if (x == one)
            begin
                x  = t;
                bt = 1;
                break;
            end
            t = x;
        end
        f = gcd64((x >= one) ? x - one : x + (n - one), n);
        r.factor = f;
        if (f > 1 || cur_cfg.s1_only)
            return r;
        sum  = add_n(inverse_n(x, n), x, n);
        wide = {sum, 64'd0};
        r.x_sum       = 64'(wide % {64'd0, n});
        r.continued   = 1'b1;
        r.backtracked = bt;
        return r;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic send_request(logic func, logic [4:0] idx, logic [63:0] word,
                                logic [63:0] modulus, bit typed, logic [63:0] typed_factor);
        res_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {3'b000, modulus, word, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (func == FUNC_LOAD)
        begin
            exp_word[idx] = word;
            loads_sent++;
        end
        else
        begin
            r = stage1_result(modulus);
            if (typed)
            begin
                r = '0;
                r.factor = typed_factor;
            end
            pending_results.push_back(r);
            runs_sent++;
        end
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            idle_cycles($urandom_range(1, 16));
        end
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for all results, then let a trailing load settle
    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        idle_cycles(8);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [5:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (addr)
            REG_WORDS:   cur_cfg.words   = val;
            REG_LEAD:    cur_cfg.lead    = val;
            REG_EXTRA:   cur_cfg.extra   = val;
            REG_S1_ONLY: cur_cfg.s1_only = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_regs(logic [5:0] w, logic [5:0] l, logic [5:0] x, logic s1);
        write_reg(REG_WORDS, w);
        write_reg(REG_LEAD, l);
        write_reg(REG_EXTRA, x);
        write_reg(REG_S1_ONLY, {5'd0, s1});
    endtask

    function automatic logic [63:0] pick_modulus();
        logic [63:0] m;
        m = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       m[0] = 1'b0;
            1, 2, 3: m = 64'($urandom_range(1, 255)) | 64'd1;
            4:       m = 64'($urandom_range(1, 32767)) | 64'd1;
            default: m[0] = 1'b1;
        endcase
        return m;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 3)
                send_request(FUNC_LOAD, 5'($urandom), {$urandom, $urandom},
                             {$urandom, $urandom}, 0, '0);
            else
                send_request(FUNC_RUN, 5'($urandom), {$urandom, $urandom},
                             pick_modulus(), 0, '0);
        end
        stop_sending();
        drain();
    endtask

    // result side: random stalls plus one long hold-off
    initial
    begin
        res_t got, want;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (results_seen == 3 && !held_off)
            begin
                m_tready <= 1'b0;
                idle_cycles(2000);
                held_off = 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                idle_cycles($urandom_range(1, 16));
            end
            m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.factor      = m_tdata[63:0];
                got.x_sum       = m_tdata[127:64];
                got.continued   = m_tdata[128];
                got.backtracked = m_tdata[129];
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $display("%t: result with nothing expected: %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.factor !== want.factor)
                    begin
                        $display("%t: factor expected %h actual %h", $time,
                                 want.factor, got.factor);
                        errors++;
                    end
                    if (got.x_sum !== want.x_sum)
                    begin
                        $display("%t: x_sum expected %h actual %h", $time,
                                 want.x_sum, got.x_sum);
                        errors++;
                    end
                    if (got.continued !== want.continued)
                    begin
                        $display("%t: continued expected %b actual %b", $time,
                                 want.continued, got.continued);
                        errors++;
                    end
                    if (got.backtracked !== want.backtracked)
                    begin
                        $display("%t: backtracked expected %b actual %b", $time,
                                 want.backtracked, got.backtracked);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        errors       = 0;
        results_seen = 0;
        runs_sent    = 0;
        loads_sent   = 0;
        no_idle      = 0;
        cur_cfg      = '{words: 6'd1, lead: 6'd0, extra: 6'd0, s1_only: 1'b1};
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = FUNC_LOAD;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_WORDS;
        cfg_wdata = '0;
        idle_cycles(11);
        rst_n <= 1'b1;
        idle_cycles(2);

        // fill the whole store so no run reads an unwritten word
        for (int i = 0; i < NWORDS; i++)
            send_request(FUNC_LOAD, 5'(i), {$urandom, $urandom}, {$urandom, $urandom}, 0, '0);

        // reset settings: no exponent bits, so x = 2 and the factor is 1 for odd n
        dir_rows = '{
            '{FUNC_RUN,  5'd0,  64'd0,  64'd3,                  1, 64'd1},
            '{FUNC_RUN,  5'd31, '1,     64'd0,                  1, 64'd0},
            '{FUNC_RUN,  5'd0,  64'd0,  64'hFFFF_FFFF_FFFF_FFFE, 1, 64'hFFFF_FFFF_FFFF_FFFE},
            '{FUNC_RUN,  5'd0,  64'd0,  64'd1,                  1, 64'd1},
            '{FUNC_RUN,  5'd0,  64'd0,  '1,                     1, 64'd1},
            '{FUNC_RUN,  5'd0,  64'd0,  64'd2,                  1, 64'd2},
            '{FUNC_LOAD, 5'd31, '1,     '1,                     0, 64'd0},
            '{FUNC_LOAD, 5'd0,  64'd0,  64'd0,                  0, 64'd0},
            '{FUNC_LOAD, 5'd1,  64'hA5A5_5A5A_0F0F_F0F0, 64'd0, 0, 64'd0},
            '{FUNC_RUN,  5'd0,  64'd0,  64'd7,                  1, 64'd1},
            '{FUNC_RUN,  5'd0,  64'd0,  64'd255,                1, 64'd1}
        };
        foreach (dir_rows[i])
            send_request(dir_rows[i].func, dir_rows[i].idx, dir_rows[i].word,
                         dir_rows[i].modulus, dir_rows[i].typed, dir_rows[i].factor);
        stop_sending();
        drain();

        // zero word count with stage 2 on, and modulus one
        set_regs(6'd0, 6'd5, 6'd3, 1'b0);
        send_request(FUNC_RUN, 5'd0, 64'd0, 64'd1, 0, '0);
        send_request(FUNC_RUN, 5'd0, 64'd0, 64'd17, 0, '0);
        send_request(FUNC_RUN, 5'd0, 64'd0, 64'd257, 0, '0);
        stop_sending();
        drain();
        // longest lead of the top word, from bit 62, crossing into the lower word
        set_regs(6'd2, 6'd63, 6'd0, 1'b0);
        random_phase(4);
        // longest run of further squarings: small moduli backtrack
        set_regs(6'd1, 6'd3, 6'd63, 1'b0);
        send_request(FUNC_RUN, 5'd0, 64'd0, 64'd5, 0, '0);
        send_request(FUNC_RUN, 5'd0, 64'd0, 64'd65537, 0, '0);
        random_phase(3);
        // oversized word count clamps to the full store
        set_regs(6'd63, 6'd0, 6'd0, 1'b1);
        send_request(FUNC_RUN, 5'd0, 64'd0, {$urandom, $urandom} | 64'd1, 0, '0);
        stop_sending();
        drain();

        for (int p = 0; p < 8; p++)
        begin
            set_regs(6'd1, 6'($urandom_range(0, 10)), 6'($urandom_range(0, 10)),
                     1'($urandom));
            if (p == 7)
                no_idle = 1;
            random_phase(7);
        end

        idle_cycles(200);
        $display("Covered %0d runs and %0d loads, %0d results checked.",
                 runs_sent, loads_sent, results_seen);
        $display("Settings spanned zero, clamped and full word counts and 0..63 squarings.");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
